@@ hdl/assert_macros.svh @@
// Assertion helpers. The bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/hnd_pkg.sv @@
`timescale 1ns / 1ps

package hnd_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int HASH_W      = 64;
   localparam int DIST_W      = 7;
   localparam int ENTRIES_W   = 5;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 1;

   localparam logic [OP_W-1:0] OP_LEARN = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_DEDUP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH = 1'd1;

   localparam logic [DIST_W-1:0] DEDUP_RESET = 7'd8;
   localparam logic [DIST_W-1:0] MATCH_RESET = 7'd15;

   // control from sequencer to one table side
   typedef struct packed {
      logic              start;
      logic              ack;
      logic [OP_W-1:0]   op;
      logic [DIST_W-1:0] limit;
   } side_ctl_type;

   // status from one table side
   typedef struct packed {
      logic done;
      logic hit;
      logic added;
      logic ovf;
   } side_sts_type;

   // adder tree popcount of a 64-bit word
   function automatic logic [DIST_W-1:0] popcount64(input logic [HASH_W-1:0] v);
      logic [1:0] s1 [32];
      logic [2:0] s2 [16];
      logic [3:0] s3 [8];
      logic [4:0] s4 [4];
      logic [5:0] s5 [2];
      for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
      for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
      for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
      return {1'b0, s5[0]} + {1'b0, s5[1]};
   endfunction

endpackage

@@ hdl/hnd_side.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One hash table: memory, fill count and a scan that reads one entry per cycle.
module hnd_side #(
   parameter int Depth = hnd_pkg::TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hnd_pkg::side_ctl_type         ctl,
   input  logic [hnd_pkg::HASH_W-1:0]    hash,
   output hnd_pkg::side_sts_type         sts,
   output logic [$clog2(Depth+1)-1:0]    fill
);

   localparam int FillW = $clog2(Depth + 1);
   localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int HashW = hnd_pkg::HASH_W;
   localparam int DistW = hnd_pkg::DIST_W;
   localparam int OpW   = hnd_pkg::OP_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } side_state_type;

   side_state_type state_ff, state_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic [FillW-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic             hit_ff, hit_in;
   logic             added_ff, added_in;
   logic             ovf_ff, ovf_in;
   logic [OpW-1:0]   op_ff, op_in;
   logic [DistW-1:0] limit_ff, limit_in;
   logic [HashW-1:0] hash_ff, hash_in;
   logic [HashW-1:0] rdata_ff;
   logic             rd_en, wr_en;
   logic [DistW-1:0] hdist;

   logic [HashW-1:0] mem [Depth];

   assign hdist = hnd_pkg::popcount64(rdata_ff ^ hash_ff);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      issue_in = issue_ff;
      pend_in  = 1'b0;
      hit_in   = hit_ff;
      added_in = added_ff;
      ovf_in   = ovf_ff;
      op_in    = op_ff;
      limit_in = limit_ff;
      hash_in  = hash_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               op_in    = ctl.op;
               limit_in = ctl.limit;
               hash_in  = hash;
               hit_in   = 1'b0;
               added_in = 1'b0;
               ovf_in   = 1'b0;
               issue_in = '0;
               if (ctl.op == hnd_pkg::OP_LEARN || ctl.op == hnd_pkg::OP_CHECK) begin
                  state_in = S_SCAN;
               end else begin
                  if (ctl.op == hnd_pkg::OP_CLEAR) fill_in = '0;
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && (hdist < limit_ff)) hit_in = 1'b1;
            if (issue_ff != fill_ff) begin
               rd_en    = 1'b1;
               issue_in = FillW'(issue_ff + 1'b1);
               pend_in  = 1'b1;
            end else if (!pend_ff) begin
               // last compare has landed in hit_ff
               state_in = S_DONE;
               if (op_ff == hnd_pkg::OP_LEARN && !hit_ff) begin
                  if (fill_ff == FillW'(Depth)) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     fill_in  = FillW'(fill_ff + 1'b1);
                     added_in = 1'b1;
                  end
               end
            end
         end
         S_DONE: begin
            if (ctl.ack) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         added_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
         hit_ff   <= hit_in;
         added_ff <= added_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      limit_ff <= limit_in;
      hash_ff  <= hash_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[issue_ff[IdxW-1:0]];
      if (wr_en) mem[fill_ff[IdxW-1:0]] <= hash_ff;
   end

   assign sts.done  = (state_ff == S_DONE);
   assign sts.hit   = hit_ff;
   assign sts.added = added_ff;
   assign sts.ovf   = ovf_ff;
   assign fill      = fill_ff;

   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff <= FillW'(Depth))
   `ASSERT_NEXT(a_done_hold, clock, reset, state_ff == S_DONE && !ctl.ack, state_ff == S_DONE)
   `ASSERT_IMPLIES(a_add_or_drop, clock, reset, state_ff == S_DONE, !(added_ff && ovf_ff))

endmodule

@@ hdl/hamming_near_duplicate_hash_store.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Learn and check scan the entries of both tables side by side between request accept and
// rsp_valid, and take longer as the fuller table holds more entries; clear and the unused
// opcode skip the scan. A new request is accepted only after the last one's result is loaded
// into the response registers; each table memory has one read port scanned one entry per
// cycle. The next request gets in while a result waits, then stalls.
// Reset (synchronous, active high): both tables empty, thresholds at 8 and 15.
module hamming_near_duplicate_hash_store #(
   parameter int TABLE_DEPTH = hnd_pkg::TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hnd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hnd_pkg::DIST_W-1:0]       csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [hnd_pkg::OP_W-1:0]         req_opcode,
   input  logic [hnd_pkg::HASH_W-1:0]       req_left_hash,
   input  logic [hnd_pkg::HASH_W-1:0]       req_right_hash,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_both_match,
   output logic                             rsp_left_match,
   output logic                             rsp_right_match,
   output logic                             rsp_left_added,
   output logic                             rsp_right_added,
   output logic                             rsp_overflow,
   output logic [hnd_pkg::ENTRIES_W-1:0]    rsp_left_entries,
   output logic [hnd_pkg::ENTRIES_W-1:0]    rsp_right_entries
);

   localparam int FillW = $clog2(TABLE_DEPTH + 1);
   localparam int EntW  = hnd_pkg::ENTRIES_W;
   localparam int HashW = hnd_pkg::HASH_W;
   localparam int DistW = hnd_pkg::DIST_W;
   localparam int OpW   = hnd_pkg::OP_W;

   typedef enum logic [1:0] {
      T_IDLE = 2'b01,
      T_BUSY = 2'b10
   } top_state_type;

   top_state_type state_ff, state_in;
   logic [DistW-1:0] dedup_ff, match_ff;
   logic [OpW-1:0]   op_ff;
   logic [HashW-1:0] lhash_ff, rhash_ff;
   logic             start_ff;
   logic             accept, load;
   logic             is_check, is_learn;

   logic             rsp_valid_ff;
   logic             both_ff, lmatch_ff, rmatch_ff, ladded_ff, radded_ff, ovf_ff;
   logic [EntW-1:0]  lent_ff, rent_ff;

   hnd_pkg::side_ctl_type ctl;
   hnd_pkg::side_sts_type left_sts, right_sts;
   logic [FillW-1:0]      left_fill, right_fill;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == T_IDLE);
   assign load      = (state_ff == T_BUSY) && left_sts.done && right_sts.done &&
                      (!rsp_valid_ff || rsp_ready);
   assign is_check  = (op_ff == hnd_pkg::OP_CHECK);
   assign is_learn  = (op_ff == hnd_pkg::OP_LEARN);

   assign ctl.start = start_ff;
   assign ctl.ack   = load;
   assign ctl.op    = op_ff;
   assign ctl.limit = is_learn ? dedup_ff : match_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE:  if (accept) state_in = T_BUSY;
         T_BUSY:  if (load) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dedup_ff     <= hnd_pkg::DEDUP_RESET;
         match_ff     <= hnd_pkg::MATCH_RESET;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
         if (load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               hnd_pkg::REG_DEDUP: dedup_ff <= csr_wdata;
               hnd_pkg::REG_MATCH: match_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         lhash_ff <= req_left_hash;
         rhash_ff <= req_right_hash;
      end
      if (load) begin
         both_ff   <= is_check && left_sts.hit && right_sts.hit;
         lmatch_ff <= is_check && left_sts.hit;
         rmatch_ff <= is_check && right_sts.hit;
         ladded_ff <= is_learn && left_sts.added;
         radded_ff <= is_learn && right_sts.added;
         ovf_ff    <= is_learn && (left_sts.ovf || right_sts.ovf);
         lent_ff   <= EntW'(left_fill);
         rent_ff   <= EntW'(right_fill);
      end
   end

   hnd_side #(.Depth(TABLE_DEPTH)) u_left (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .hash  (lhash_ff),
      .sts   (left_sts),
      .fill  (left_fill)
   );

   hnd_side #(.Depth(TABLE_DEPTH)) u_right (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .hash  (rhash_ff),
      .sts   (right_sts),
      .fill  (right_fill)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_both_match    = both_ff;
   assign rsp_left_match    = lmatch_ff;
   assign rsp_right_match   = rmatch_ff;
   assign rsp_left_added    = ladded_ff;
   assign rsp_right_added   = radded_ff;
   assign rsp_overflow      = ovf_ff;
   assign rsp_left_entries  = lent_ff;
   assign rsp_right_entries = rent_ff;

   `ASSERT_IMPLIES(a_start_sides_idle, clock, reset, start_ff, !left_sts.done && !right_sts.done)
   `ASSERT_NEXT(a_busy_hold, clock, reset, state_ff == T_BUSY && !load, state_ff == T_BUSY)
   `ASSERT_IMPLIES(a_learn_check_excl, clock, reset,
                   rsp_valid_ff && (ladded_ff || radded_ff || ovf_ff), !lmatch_ff && !rmatch_ff)

endmodule
